/* rtl/ras_pkg.sv */
// shared types and constants for the rational add/sub unit
// used by ras_alu and rational_add_sub_unit
package ras_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FIELD_BITS    = 32;
   localparam int DEN_BITS      = 31;
   localparam int WIDE_BITS     = 64;
   localparam int MUL_BITS      = 32;
   localparam int CNT_BITS      = $clog2(WIDE_BITS);

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NORM = 2'd0;
   localparam kind_type KIND_ADD  = 2'd1;
   localparam kind_type KIND_SUB  = 2'd2;
   localparam kind_type KIND_CMP  = 2'd3;

   typedef logic [1:0] alu_op_type;
   localparam alu_op_type ALU_GCD = 2'd0;
   localparam alu_op_type ALU_DIV = 2'd1;
   localparam alu_op_type ALU_MUL = 2'd2;

   typedef struct packed {
      logic                 start;
      alu_op_type           op;
      logic [WIDE_BITS-1:0] opa;
      logic [WIDE_BITS-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic                 done;
      logic [WIDE_BITS-1:0] result;
   } alu_rsp_type;

endpackage

/* rtl/ras_alu.sv */
// shared iterative unit: binary gcd, restoring divide, shift-add multiply
// depends on ras_pkg
module ras_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  ras_pkg::alu_req_type req,
   output ras_pkg::alu_rsp_type rsp
);
   import ras_pkg::*;

   localparam logic [2:0] A_IDLE = 3'd0;
   localparam logic [2:0] A_GCD  = 3'd1;
   localparam logic [2:0] A_GSH  = 3'd2;
   localparam logic [2:0] A_DIV  = 3'd3;
   localparam logic [2:0] A_MUL  = 3'd4;

   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(WIDE_BITS - 1);
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_BITS - 1);

   logic [2:0]           st_ff, st_in;
   logic [WIDE_BITS-1:0] x_ff, x_in, y_ff, y_in, r_ff, r_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WIDE_BITS:0]   trial;
   logic                 ge;

   assign trial = {r_ff, x_ff[WIDE_BITS-1]};
   assign ge    = trial >= {1'b0, y_ff};

   always_comb begin
      st_in   = st_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      unique case (st_ff)
         A_IDLE: begin
            if (req.start) begin
               x_in   = req.opa;
               y_in   = req.opb;
               r_in   = '0;
               cnt_in = '0;
               unique case (req.op)
                  ALU_GCD: st_in = A_GCD;
                  ALU_DIV: st_in = A_DIV;
                  ALU_MUL: st_in = A_MUL;
                  default: begin
                     st_in   = A_IDLE;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         A_GCD: begin
            if (x_ff == '0) begin
               r_in  = y_ff;
               st_in = A_GSH;
            end else if (y_ff == '0) begin
               r_in  = x_ff;
               st_in = A_GSH;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in   = x_ff >> 1;
               y_in   = y_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         A_GSH: begin
            if (cnt_ff == '0) begin
               done_in = 1'b1;
               st_in   = A_IDLE;
            end else begin
               r_in   = r_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         A_DIV: begin
            r_in   = ge ? trial[WIDE_BITS-1:0] - y_ff : trial[WIDE_BITS-1:0];
            x_in   = {x_ff[WIDE_BITS-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               r_in    = {x_ff[WIDE_BITS-2:0], ge};
               done_in = 1'b1;
               st_in   = A_IDLE;
            end
         end
         A_MUL: begin
            if (x_ff[0]) begin
               r_in = r_ff + y_ff;
            end
            x_in   = x_ff >> 1;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               done_in = 1'b1;
               st_in   = A_IDLE;
            end
         end
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = r_ff;

endmodule

/* rtl/rational_add_sub_unit.sv */
// top level: sequencer for exact rational normalize, add, subtract, compare
// depends on ras_pkg and ras_alu
//
//   channel   ports                     handshake
//   request   req_*                     start high while busy low
//   response  rsp_*                     rsp_valid strobe, one cycle, no stall
//
// the time an item takes from acceptance to the result strobe is set by the
// single shared gcd/divide/multiply unit, which runs three reductions, one lcm
// gcd, two divides and three multiplies for add or subtract.
// busy stays high from acceptance until the result strobe.
// reset clears the sequencer and the strobe; there is nothing else to clear.
module rational_add_sub_unit #(
   parameter int WORD_BITS = ras_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ras_pkg::kind_type                   req_kind,
   input  logic signed [ras_pkg::FIELD_BITS-1:0] req_a_num,
   input  logic signed [ras_pkg::FIELD_BITS-1:0] req_a_den,
   input  logic signed [ras_pkg::FIELD_BITS-1:0] req_b_num,
   input  logic [ras_pkg::DEN_BITS-1:0]        req_b_den,
   output logic                                rsp_valid,
   output logic signed [ras_pkg::FIELD_BITS-1:0] rsp_res_num,
   output logic [ras_pkg::DEN_BITS-1:0]        rsp_res_den,
   output logic                                rsp_is_equal,
   output logic                                rsp_overflow,
   output logic                                rsp_bad_den
);
   import ras_pkg::*;

   localparam int LIM_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam logic [WIDE_BITS-1:0] LIM = (64'd1 << (LIM_BITS - 1)) - 64'd1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RED_G   = 4'd1;
   localparam logic [3:0] S_RED_N   = 4'd2;
   localparam logic [3:0] S_RED_D   = 4'd3;
   localparam logic [3:0] S_RED_END = 4'd4;
   localparam logic [3:0] S_LCM_G   = 4'd5;
   localparam logic [3:0] S_LCM_FA  = 4'd6;
   localparam logic [3:0] S_LCM_FB  = 4'd7;
   localparam logic [3:0] S_LCM_L   = 4'd8;
   localparam logic [3:0] S_LCM_TA  = 4'd9;
   localparam logic [3:0] S_LCM_TB  = 4'd10;
   localparam logic [3:0] S_COMB    = 4'd11;
   localparam logic [3:0] S_FIN     = 4'd12;

   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_R = 2'd2;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [3:0]            st_ff, st_in;
   logic [1:0]            ph_ff, ph_in;
   logic                  pend_ff, pend_in;
   kind_type              kind_ff, kind_in;
   logic                  bad_ff, bad_in, eq_ff, eq_in;
   logic [FIELD_BITS-1:0] bn_mag_ff, bn_mag_in;
   logic                  bn_neg_ff, bn_neg_in;
   logic [DEN_BITS-1:0]   bd_ff, bd_in;
   logic [WIDE_BITS-1:0]  rn_ff, rn_in, rd_ff, rd_in, g_ff, g_in;
   logic                  rneg_ff, rneg_in;
   logic                  a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [FIELD_BITS-1:0] a_mag_ff, a_mag_in, a_den_ff, a_den_in;
   logic [FIELD_BITS-1:0] b_mag_ff, b_mag_in, b_den_ff, b_den_in;
   logic [FIELD_BITS-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic [WIDE_BITS-1:0]  l_ff, l_in, ta_ff, ta_in, tb_ff, tb_in;
   logic                  vld_ff, vld_in, ovf_ff, ovf_in;
   logic [FIELD_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;
   logic                  req_eq_ff, req_eq_in;
   logic                  req_bad_ff, req_bad_in;

   logic [FIELD_BITS-1:0] an_mag, ad_mag, bn_mag;
   logic                  sb;
   logic                  alu_state;
   logic                  accept;

   assign an_mag = req_a_num[FIELD_BITS-1] ? (~req_a_num + 1'b1) : req_a_num;
   assign ad_mag = req_a_den[FIELD_BITS-1] ? (~req_a_den + 1'b1) : req_a_den;
   assign bn_mag = req_b_num[FIELD_BITS-1] ? (~req_b_num + 1'b1) : req_b_num;
   assign accept = start && !busy;
   assign sb     = (kind_ff == KIND_SUB) ? !b_neg_ff : b_neg_ff;

   ras_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_comb begin
      alu_state   = 1'b1;
      alu_req.op  = ALU_DIV;
      alu_req.opa = '0;
      alu_req.opb = '0;
      unique case (st_ff)
         S_RED_G: begin
            alu_req.op  = ALU_GCD;
            alu_req.opa = rn_ff;
            alu_req.opb = rd_ff;
            alu_state   = rn_ff != '0;
         end
         S_RED_N: begin
            alu_req.opa = rn_ff;
            alu_req.opb = g_ff;
         end
         S_RED_D: begin
            alu_req.opa = rd_ff;
            alu_req.opb = g_ff;
         end
         S_LCM_G: begin
            alu_req.op  = ALU_GCD;
            alu_req.opa = {32'd0, a_den_ff};
            alu_req.opb = {32'd0, b_den_ff};
         end
         S_LCM_FA: begin
            alu_req.opa = {32'd0, b_den_ff};
            alu_req.opb = g_ff;
         end
         S_LCM_FB: begin
            alu_req.opa = {32'd0, a_den_ff};
            alu_req.opb = g_ff;
         end
         S_LCM_L: begin
            alu_req.op  = ALU_MUL;
            alu_req.opa = {32'd0, fb_ff};
            alu_req.opb = {32'd0, b_den_ff};
         end
         S_LCM_TA: begin
            alu_req.op  = ALU_MUL;
            alu_req.opa = {32'd0, a_mag_ff};
            alu_req.opb = {32'd0, fa_ff};
         end
         S_LCM_TB: begin
            alu_req.op  = ALU_MUL;
            alu_req.opa = {32'd0, b_mag_ff};
            alu_req.opb = {32'd0, fb_ff};
         end
         default: alu_state = 1'b0;
      endcase
      alu_req.start = alu_state && !pend_ff;
   end

   always_comb begin
      st_in      = st_ff;
      ph_in      = ph_ff;
      pend_in    = pend_ff;
      kind_in    = kind_ff;
      bad_in     = bad_ff;
      eq_in      = eq_ff;
      bn_mag_in  = bn_mag_ff;
      bn_neg_in  = bn_neg_ff;
      bd_in      = bd_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      g_in       = g_ff;
      rneg_in    = rneg_ff;
      a_neg_in   = a_neg_ff;
      a_mag_in   = a_mag_ff;
      a_den_in   = a_den_ff;
      b_neg_in   = b_neg_ff;
      b_mag_in   = b_mag_ff;
      b_den_in   = b_den_ff;
      fa_in      = fa_ff;
      fb_in      = fb_ff;
      l_in       = l_ff;
      ta_in      = ta_ff;
      tb_in      = tb_ff;
      vld_in     = 1'b0;
      num_in     = num_ff;
      den_in     = den_ff;
      ovf_in     = ovf_ff;
      req_eq_in  = req_eq_ff;
      req_bad_in = req_bad_ff;

      if (alu_rsp.done) begin
         pend_in = 1'b0;
      end else if (alu_req.start) begin
         pend_in = 1'b1;
      end

      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               bn_mag_in = bn_mag;
               bn_neg_in = req_b_num[FIELD_BITS-1];
               bd_in     = req_b_den;
               rn_in     = {32'd0, an_mag};
               rd_in     = {32'd0, ad_mag};
               rneg_in   = req_a_num[FIELD_BITS-1] ^ req_a_den[FIELD_BITS-1];
               ph_in     = PH_A;
               eq_in     = 1'b0;
               bad_in    = (ad_mag == '0) ||
                           ((req_kind != KIND_NORM) && (req_b_den == '0));
               st_in     = bad_in ? S_FIN : S_RED_G;
            end
         end
         S_RED_G: begin
            if (rn_ff == '0) begin
               rneg_in = 1'b0;
               rd_in   = 64'd1;
               st_in   = S_RED_END;
            end else if (alu_rsp.done) begin
               g_in  = alu_rsp.result;
               st_in = S_RED_N;
            end
         end
         S_RED_N: begin
            if (alu_rsp.done) begin
               rn_in = alu_rsp.result;
               st_in = S_RED_D;
            end
         end
         S_RED_D: begin
            if (alu_rsp.done) begin
               rd_in = alu_rsp.result;
               st_in = S_RED_END;
            end
         end
         S_RED_END: begin
            unique case (ph_ff)
               PH_A: begin
                  a_neg_in = rneg_ff;
                  a_mag_in = rn_ff[FIELD_BITS-1:0];
                  a_den_in = rd_ff[FIELD_BITS-1:0];
                  if (kind_ff == KIND_NORM) begin
                     st_in = S_FIN;
                  end else begin
                     rn_in   = {32'd0, bn_mag_ff};
                     rd_in   = {33'd0, bd_ff};
                     rneg_in = bn_neg_ff;
                     ph_in   = PH_B;
                     st_in   = S_RED_G;
                  end
               end
               PH_B: begin
                  b_neg_in = rneg_ff;
                  b_mag_in = rn_ff[FIELD_BITS-1:0];
                  b_den_in = rd_ff[FIELD_BITS-1:0];
                  if (kind_ff == KIND_CMP) begin
                     eq_in = (a_neg_ff == rneg_ff) && ({32'd0, a_mag_ff} == rn_ff) &&
                             ({32'd0, a_den_ff} == rd_ff);
                     st_in = S_FIN;
                  end else begin
                     st_in = S_LCM_G;
                  end
               end
               default: st_in = S_FIN;
            endcase
         end
         S_LCM_G: begin
            if (alu_rsp.done) begin
               g_in  = alu_rsp.result;
               st_in = S_LCM_FA;
            end
         end
         S_LCM_FA: begin
            if (alu_rsp.done) begin
               fa_in = alu_rsp.result[FIELD_BITS-1:0];
               st_in = S_LCM_FB;
            end
         end
         S_LCM_FB: begin
            if (alu_rsp.done) begin
               fb_in = alu_rsp.result[FIELD_BITS-1:0];
               st_in = S_LCM_L;
            end
         end
         S_LCM_L: begin
            if (alu_rsp.done) begin
               l_in  = alu_rsp.result;
               st_in = S_LCM_TA;
            end
         end
         S_LCM_TA: begin
            if (alu_rsp.done) begin
               ta_in = alu_rsp.result;
               st_in = S_LCM_TB;
            end
         end
         S_LCM_TB: begin
            if (alu_rsp.done) begin
               tb_in = alu_rsp.result;
               st_in = S_COMB;
            end
         end
         S_COMB: begin
            if (a_neg_ff == sb) begin
               rn_in   = ta_ff + tb_ff;
               rneg_in = a_neg_ff;
            end else if (ta_ff >= tb_ff) begin
               rn_in   = ta_ff - tb_ff;
               rneg_in = a_neg_ff;
            end else begin
               rn_in   = tb_ff - ta_ff;
               rneg_in = sb;
            end
            rd_in = l_ff;
            ph_in = PH_R;
            st_in = S_RED_G;
         end
         S_FIN: begin
            vld_in     = 1'b1;
            num_in     = '0;
            den_in     = DEN_BITS'(1);
            ovf_in     = 1'b0;
            req_eq_in  = 1'b0;
            req_bad_in = 1'b0;
            if (bad_ff) begin
               req_bad_in = 1'b1;
            end else if (kind_ff == KIND_CMP) begin
               req_eq_in = eq_ff;
            end else if ((rn_ff > LIM) || (rd_ff > LIM)) begin
               ovf_in = 1'b1;
            end else begin
               num_in = rneg_ff ? (~rn_ff[FIELD_BITS-1:0] + 1'b1) : rn_ff[FIELD_BITS-1:0];
               den_in = rd_ff[DEN_BITS-1:0];
            end
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         pend_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
      ph_ff      <= ph_in;
      kind_ff    <= kind_in;
      bad_ff     <= bad_in;
      eq_ff      <= eq_in;
      bn_mag_ff  <= bn_mag_in;
      bn_neg_ff  <= bn_neg_in;
      bd_ff      <= bd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      g_ff       <= g_in;
      rneg_ff    <= rneg_in;
      a_neg_ff   <= a_neg_in;
      a_mag_ff   <= a_mag_in;
      a_den_ff   <= a_den_in;
      b_neg_ff   <= b_neg_in;
      b_mag_ff   <= b_mag_in;
      b_den_ff   <= b_den_in;
      fa_ff      <= fa_in;
      fb_ff      <= fb_in;
      l_ff       <= l_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      ovf_ff     <= ovf_in;
      req_eq_ff  <= req_eq_in;
      req_bad_ff <= req_bad_in;
   end

   assign busy         = st_ff != S_IDLE;
   assign rsp_valid    = vld_ff;
   assign rsp_res_num  = num_ff;
   assign rsp_res_den  = den_ff;
   assign rsp_is_equal = req_eq_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_bad_den  = req_bad_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted item did not start");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_den |-> rsp_res_num == '0 && rsp_res_den == DEN_BITS'(1)
      && !rsp_overflow && !rsp_is_equal) else $error("bad denominator result not 0/1");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_res_num == '0 && !rsp_is_equal)
      else $error("overflow result not cleared");

endmodule

/* verif/rational_add_sub_checker.sv */
`timescale 1ns / 1ps
// checker for the rational add/sub unit: watches request and response ports,
// predicts each result with an exact rational model and compares field by field
// depends on ras_pkg
module rational_add_sub_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  ras_pkg::kind_type    req_kind,
   input  logic signed [31:0]   req_a_num,
   input  logic signed [31:0]   req_a_den,
   input  logic signed [31:0]   req_b_num,
   input  logic [30:0]          req_b_den,
   input  logic                 rsp_valid,
   input  logic signed [31:0]   rsp_res_num,
   input  logic [30:0]          rsp_res_den,
   input  logic                 rsp_is_equal,
   input  logic                 rsp_overflow,
   input  logic                 rsp_bad_den,
   output int                   fail_count,
   output int                   pending
);
   import ras_pkg::*;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        eq;
      logic        ovf;
      logic        bad;
   } rational_result_type;

   typedef struct {
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
   } frac_type;

   rational_result_type expected_results[$];
   int mismatches;

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
   endfunction

   function automatic frac_type reduce_frac(bit neg, logic [63:0] mag, logic [63:0] den);
      frac_type r;
      logic [63:0] g;
      if (mag == 0) begin
         r.neg = 0;
         r.mag = 0;
         r.den = 1;
      end else begin
         g = gcd64(mag, den);
         r.neg = neg;
         r.mag = mag / g;
         r.den = den / g;
      end
      return r;
   endfunction

   function automatic rational_result_type predict_rational(kind_type kind,
         logic [31:0] an_raw, logic [31:0] ad_raw, logic [31:0] bn_raw,
         logic [30:0] bd_raw);
      rational_result_type r;
      frac_type a, b, res;
      logic [63:0] ad, bd, g, fa, fb, l, ta, tb, m;
      bit sb, s, have;
      r = '{num: 0, den: 1, eq: 0, ovf: 0, bad: 0};
      ad = magnitude(ad_raw);
      bd = {33'd0, bd_raw};
      have = 1;
      if (ad == 0 || (kind != KIND_NORM && bd == 0)) begin
         r.bad = 1;
      end else begin
         a = reduce_frac(an_raw[31] != ad_raw[31], magnitude(an_raw), ad);
         res = a;
         if (kind != KIND_NORM) begin
            b = reduce_frac(bn_raw[31], magnitude(bn_raw), bd);
            if (kind == KIND_CMP) begin
               r.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
               have = 0;
            end else begin
               g = gcd64(a.den, b.den);
               fa = b.den / g;
               fb = a.den / g;
               l = fb * b.den;
               ta = a.mag * fa;
               tb = b.mag * fb;
               sb = (kind == KIND_SUB) ? !b.neg : b.neg;
               if (a.neg == sb) begin
                  m = ta + tb;
                  s = a.neg;
               end else if (ta >= tb) begin
                  m = ta - tb;
                  s = a.neg;
               end else begin
                  m = tb - ta;
                  s = sb;
               end
               res = reduce_frac(s, m, l);
            end
         end
         if (have) begin
            if (res.mag > 64'h7fff_ffff || res.den > 64'h7fff_ffff) begin
               r.ovf = 1;
            end else begin
               r.num = res.neg ? 32'd0 - res.mag[31:0] : res.mag[31:0];
               r.den = res.den[30:0];
            end
         end
      end
      return r;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      rational_result_type e;
      rational_result_type got;
      if (reset) begin
         fail_count <= 0;
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            got = '{num: rsp_res_num, den: rsp_res_den, eq: rsp_is_equal,
                    ovf: rsp_overflow, bad: rsp_bad_den};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result num=%0d den=%0d", $signed(got.num), got.den);
            end else begin
               e = expected_results.pop_front();
               if (got !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp num=%0d den=%0d eq=%b ovf=%b bad=%b",
                               " got num=%0d den=%0d eq=%b ovf=%b bad=%b"},
                        $signed(e.num), e.den, e.eq, e.ovf, e.bad,
                        $signed(got.num), got.den, got.eq, got.ovf, got.bad);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_rational(req_kind, req_a_num, req_a_den,
               req_b_num, req_b_den));
         fail_count <= mismatches;
      end
   end
endmodule

/* verif/tb_rational_add_sub_unit.sv */
`timescale 1ns / 1ps
// testbench top for the rational add/sub unit: drives directed and random items
// depends on ras_pkg, rational_add_sub_unit and rational_add_sub_checker
module tb_rational_add_sub_unit;
   import ras_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   kind_type          req_kind = KIND_NORM;
   logic signed [31:0] req_a_num = 0, req_a_den = 1, req_b_num = 0;
   logic [30:0]       req_b_den = 1;
   logic              rsp_valid, rsp_is_equal, rsp_overflow, rsp_bad_den;
   logic signed [31:0] rsp_res_num;
   logic [30:0]       rsp_res_den;
   int                fail_count, pending;
   longint            cycles = 0;
   int                idle_pct = 0;

   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int MIN_INT = 32'sh8000_0000;
   localparam int MAX_INT = 32'sh7fff_ffff;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   rational_add_sub_unit uut (.*);
   rational_add_sub_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_rational_add_sub_unit failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom_range(0, 2000) - 1000;
         2: return $urandom & 32'h0000_ffff;
         3: return $urandom | 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // start is held for exactly the accept edge, busy is low on entry
   task automatic send_item(kind_type k, logic [31:0] an, logic [31:0] ad,
         logic [31:0] bn, logic [30:0] bd);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      req_kind <= k;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      start <= 1;
      @(posedge clock);
      start <= 0;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] an, ad, bn;
      logic [30:0] bd;
      an = rand_word();
      ad = rand_word();
      bn = rand_word();
      bd = 31'(rand_word());
      if ($urandom_range(0, 9) != 0) begin
         if (ad == 0) ad = 32'd1;
         if (bd == 0) bd = 31'd1;
      end
      send_item(kind_type'($urandom_range(0, 3)), an, ad, bn, bd);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(KIND_NORM, 6, -4, 0, 1);
      send_item(KIND_NORM, 0, -7, 0, 1);
      send_item(KIND_NORM, 0, 0, 0, 1);
      send_item(KIND_NORM, 5, 0, 0, 0);
      send_item(KIND_NORM, MIN_INT, 1, 0, 1);
      send_item(KIND_NORM, MIN_INT, 2, 0, 1);
      send_item(KIND_NORM, MIN_INT, MIN_INT, 0, 1);
      send_item(KIND_NORM, MAX_INT, MIN_INT, 0, 1);
      send_item(KIND_ADD, 1, 2, 1, 3);
      send_item(KIND_ADD, MAX_INT, 1, MAX_INT, 1);
      send_item(KIND_ADD, 1, MAX_INT, 1, 31'h7fff_fffe);
      send_item(KIND_ADD, 3, 1, 2, 0);
      send_item(KIND_SUB, 1, 2, 1, 2);
      send_item(KIND_SUB, MIN_INT, 1, MAX_INT, 1);
      send_item(KIND_SUB, -5, 6, -7, 31'h7fff_ffff);
      send_item(KIND_SUB, 4, -8, 6, 12);
      send_item(KIND_CMP, 2, 4, 1, 2);
      send_item(KIND_CMP, -2, 4, 1, 2);
      send_item(KIND_CMP, 2, -4, -1, 2);
      send_item(KIND_CMP, 0, 5, 0, 1);
      send_item(KIND_CMP, 1, 1, 1, 0);
      send_item(KIND_CMP, 1, 0, 1, 1);
      send_item(KIND_NORM, -1, -1, -1, 31'h7fff_ffff);
      idle_pct = 29;
      repeat (450) send_random();
      while (pending != 0) @(posedge clock);
      idle_pct = 50;
      repeat (450) send_random();
      idle_pct = 0;
      repeat (450) send_random();
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb_rational_add_sub_unit passed");
      else
         $display("tb_rational_add_sub_unit failed");
      $finish;
   end
endmodule
